// File: rtl/pvc_pkg.sv
`timescale 1ns / 1ps

package pvc_pkg;

  localparam int CodeW   = 28;
  localparam int ByteW   = 8;
  localparam int MaxRes  = 4;   // most result items one input item can give
  localparam int RemW    = 3;   // holds 0..MaxRes
  localparam int PendW   = 2;

  // leading-byte prefixes of a run
  localparam logic [3:0] Lead4Tag = 4'hE;   // 1110xxxx, three more bytes
  localparam logic [2:0] Lead3Tag = 3'h6;   // 110xxxxx, two more bytes
  localparam logic [1:0] Lead2Tag = 2'h2;   // 10xxxxxx, one more byte

  localparam logic [ByteW-1:0] Lead4Pfx = 8'hE0;
  localparam logic [ByteW-1:0] Lead3Pfx = 8'hC0;
  localparam logic [ByteW-1:0] Lead2Pfx = 8'h80;

  localparam logic [PendW-1:0] Pend4 = 2'd3;
  localparam logic [PendW-1:0] Pend3 = 2'd2;
  localparam logic [PendW-1:0] Pend2 = 2'd1;

  // result bundle handed from the translate stage to the output buffer
  typedef struct packed {
    logic [RemW-1:0]                num;      // number of result items, 1..MaxRes
    logic [MaxRes-1:0][ByteW-1:0]   bytes;    // element 0 leaves first
    logic [CodeW-1:0]               code;
    logic                           str_end;
  } pvc_res_t;

endpackage

// File: rtl/pvc_in_stage.sv
`timescale 1ns / 1ps

module pvc_in_stage
  import pvc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CodeW-1:0] in_code_in,
  input  logic [ByteW-1:0] in_byte_in,
  input  logic             take,
  output logic             hold_vld,
  output logic [CodeW-1:0] hold_code,
  output logic [ByteW-1:0] hold_byte
);

  logic             vld_r, vld_nxt;
  logic [CodeW-1:0] code_r;
  logic [ByteW-1:0] byte_r;
  logic             acc;

  assign in_ready = !vld_r || take;
  assign acc      = in_valid && in_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (acc) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      code_r <= in_code_in;
      byte_r <= in_byte_in;
    end
  end

  assign hold_vld  = vld_r;
  assign hold_code = code_r;
  assign hold_byte = byte_r;

endmodule

// File: rtl/pvc_xlate.sv
`timescale 1ns / 1ps

module pvc_xlate
  import pvc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  input  logic             hold_vld,
  input  logic [CodeW-1:0] hold_code,
  input  logic [ByteW-1:0] hold_byte,
  input  logic             buf_free,
  output logic             take,
  output logic             load,
  output pvc_res_t         res
);

  logic             dir_r;
  logic [PendW-1:0] pend_r, pend_nxt;
  logic [CodeW-1:0] acc_r, acc_nxt;
  logic             dec_emit;
  logic [CodeW-1:0] dec_code;
  logic [CodeW-1:0] shifted;
  logic             has_res;
  pvc_res_t         enc_res;
  pvc_res_t         dec_res;

  // encoder: one plain byte below 128, else a prefixed run, MSB first
  always_comb begin
    enc_res       = '0;
    enc_res.code  = '0;
    if (hold_code[CodeW-1:7] == '0) begin
      enc_res.num      = RemW'(1);
      enc_res.bytes[0] = {1'b0, hold_code[6:0]};
      enc_res.str_end  = (hold_code[6:0] == '0);
    end else if (hold_code[CodeW-1:14] == '0) begin
      enc_res.num      = RemW'(2);
      enc_res.bytes[0] = Lead2Pfx | {2'b00, hold_code[13:8]};
      enc_res.bytes[1] = hold_code[7:0];
    end else if (hold_code[CodeW-1:21] == '0) begin
      enc_res.num      = RemW'(3);
      enc_res.bytes[0] = Lead3Pfx | {3'b000, hold_code[20:16]};
      enc_res.bytes[1] = hold_code[15:8];
      enc_res.bytes[2] = hold_code[7:0];
    end else begin
      enc_res.num      = RemW'(4);
      enc_res.bytes[0] = Lead4Pfx | {4'h0, hold_code[27:24]};
      enc_res.bytes[1] = hold_code[23:16];
      enc_res.bytes[2] = hold_code[15:8];
      enc_res.bytes[3] = hold_code[7:0];
    end
  end

  // decoder: leading byte sets the run length, later bytes shift in
  assign shifted = {acc_r[CodeW-ByteW-1:0], hold_byte};

  always_comb begin
    pend_nxt = pend_r;
    acc_nxt  = acc_r;
    dec_emit = 1'b0;
    dec_code = '0;
    if (pend_r == '0) begin
      priority if (hold_byte[7:4] == Lead4Tag) begin
        acc_nxt  = {{(CodeW-4){1'b0}}, hold_byte[3:0]};
        pend_nxt = Pend4;
      end else if (hold_byte[7:5] == Lead3Tag) begin
        acc_nxt  = {{(CodeW-5){1'b0}}, hold_byte[4:0]};
        pend_nxt = Pend3;
      end else if (hold_byte[7:6] == Lead2Tag) begin
        acc_nxt  = {{(CodeW-6){1'b0}}, hold_byte[5:0]};
        pend_nxt = Pend2;
      end else begin
        // plain byte, including the 1111xxxx leads
        dec_emit = 1'b1;
        dec_code = {{(CodeW-ByteW){1'b0}}, hold_byte};
      end
    end else begin
      pend_nxt = pend_r - PendW'(1);
      if (pend_r == PendW'(1)) begin
        dec_emit = 1'b1;
        dec_code = shifted;
        acc_nxt  = '0;
      end else begin
        acc_nxt = shifted;
      end
    end
  end

  always_comb begin
    dec_res         = '0;
    dec_res.num     = RemW'(1);
    dec_res.code    = dec_code;
    dec_res.str_end = (dec_code == '0);
  end

  assign res     = dir_r ? dec_res : enc_res;
  assign has_res = dir_r ? dec_emit : 1'b1;
  // mid-run decode bytes leave without waiting on the output buffer
  assign take    = hold_vld && (!has_res || buf_free);
  assign load    = take && has_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r  <= 1'b0;
      pend_r <= '0;
      acc_r  <= '0;
    end else if (cfg_we) begin
      dir_r  <= cfg_wdata;
      pend_r <= '0;
      acc_r  <= '0;
    end else if (take && dir_r) begin
      pend_r <= pend_nxt;
      acc_r  <= acc_nxt;
    end
  end

`ifndef SYNTHESIS
  a_pend_only_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r != '0) |-> dir_r)
    else $error("decoder run pending while encoding");
`endif

endmodule

// File: rtl/pvc_out_buf.sv
`timescale 1ns / 1ps

module pvc_out_buf
  import pvc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  pvc_res_t         res,
  output logic             buf_free,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ByteW-1:0] out_byte_out,
  output logic [CodeW-1:0] out_code_out,
  output logic             out_run_last,
  output logic             out_string_end
);

  logic [RemW-1:0]              rem_r, rem_nxt;
  logic [MaxRes-1:0][ByteW-1:0] bytes_r, bytes_nxt;
  logic [CodeW-1:0]             code_r;
  logic                         end_r;
  logic                         pop;

  assign out_valid = (rem_r != '0);
  assign pop       = out_valid && out_ready;
  assign buf_free  = (rem_r == '0) || ((rem_r == RemW'(1)) && out_ready);

  always_comb begin
    rem_nxt   = rem_r;
    bytes_nxt = bytes_r;
    if (load) begin
      rem_nxt   = res.num;
      bytes_nxt = res.bytes;
    end else if (pop) begin
      rem_nxt   = rem_r - RemW'(1);
      bytes_nxt = {{ByteW{1'b0}}, bytes_r[MaxRes-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
    if (load) begin
      code_r <= res.code;
      end_r  <= res.str_end;
    end
  end

  assign out_byte_out   = bytes_r[0];
  assign out_code_out   = code_r;
  assign out_run_last   = (rem_r == RemW'(1));
  assign out_string_end = end_r && (rem_r == RemW'(1));

`ifndef SYNTHESIS
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= RemW'(MaxRes))
    else $error("output buffer count out of range");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> ((rem_r == '0) || ((rem_r == RemW'(1)) && out_ready)))
    else $error("output buffer loaded over pending items");

  a_code_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (code_r != '0)) |-> (rem_r == RemW'(1)))
    else $error("decoded code spread over several items");
`endif

endmodule

// File: rtl/prefix_varint_char_codec_unit.sv
`timescale 1ns / 1ps

// Prefix varint character codec.
// Input channel (in_valid/in_ready): one item carries in_code_in (encode)
// and in_byte_in (decode); only the field of the current direction matters.
// Output channel (out_valid/out_ready): one item per byte when encoding
// (1 to 4 items, MSB-first, run_last on the final byte, string_end on a
// zero code); one item per completed run when decoding (code_out, run_last
// always set). Mid-run decode bytes give no item.
// cfg_we/cfg_wdata write direction (0 encode, 1 decode) and drop any partial
// decode run; write only while the block is idle.
// An accepted item passes through the input register and then the output
// buffer register before its first result shows on the outputs.
// Throughput: the output buffer sends one byte per cycle while out_ready is
// high; decode takes one byte per cycle while no completed run is stalled.
// Reset (rst_n low, synchronous) empties both stages, selects encode and
// clears the decoder. When the receiver stalls, the current result holds and
// one further input item waits in the input register before in_ready drops.
module prefix_varint_char_codec_unit
  import pvc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CodeW-1:0] in_code_in,
  input  logic [ByteW-1:0] in_byte_in,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ByteW-1:0] out_byte_out,
  output logic [CodeW-1:0] out_code_out,
  output logic             out_run_last,
  output logic             out_string_end
);

  logic             take;
  logic             load;
  logic             buf_free;
  logic             hold_vld;
  logic [CodeW-1:0] hold_code;
  logic [ByteW-1:0] hold_byte;
  pvc_res_t         res;

  // input register
  pvc_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_code_in(in_code_in),
    .in_byte_in(in_byte_in),
    .take      (take),
    .hold_vld  (hold_vld),
    .hold_code (hold_code),
    .hold_byte (hold_byte)
  );

  // encode/decode logic plus direction and decoder run state
  pvc_xlate u_xlate (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .hold_vld (hold_vld),
    .hold_code(hold_code),
    .hold_byte(hold_byte),
    .buf_free (buf_free),
    .take     (take),
    .load     (load),
    .res      (res)
  );

  // result register, shifts out one byte per accepted item
  pvc_out_buf u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (load),
    .res           (res),
    .buf_free      (buf_free),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte_out  (out_byte_out),
    .out_code_out  (out_code_out),
    .out_run_last  (out_run_last),
    .out_string_end(out_string_end)
  );

endmodule
